>>> src/jdc_pkg.sv
`timescale 1ns / 1ps

package jdc_pkg;

   // field widths
   localparam int DAY_W  = 23;
   localparam int MS_W   = 27;
   localparam int YEAR_W = 14;
   localparam int MON_W  = 4;
   localparam int DOM_W  = 5;
   localparam int HR_W   = 5;
   localparam int MIN_W  = 6;
   localparam int SEC_W  = 6;
   localparam int MSEC_W = 10;

   // pipeline depth
   localparam int NUM_STAGES = 14;

   // calendar constants
   localparam logic signed [23:0]    JD_J2000       = 24'sd2451545;
   localparam logic signed [DAY_W-1:0] GREG_DAY_INDEX = -23'sd152384;
   localparam logic signed [25:0]    AL_NUM_OFFSET  = 26'sd2337315;
   localparam logic signed [23:0]    B_OFFSET       = 24'sd1524;
   localparam logic signed [31:0]    C_NUM_OFFSET   = 32'sd182612790;
   localparam logic signed [15:0]    C_BIAS         = 16'sd5000;
   localparam logic signed [15:0]    YEAR_OFS_LATE  = 16'sd4716;
   localparam logic signed [15:0]    YEAR_OFS_EARLY = 16'sd4715;
   localparam logic [MS_W-1:0]       MS_MAX         = 27'd86399999;

   // reciprocal constant dividers
   localparam logic [18:0] AL_DIV   = 19'd146097;
   localparam logic [7:0]  AL_RECIP = 8'd229;
   localparam logic [16:0] C_DIV    = 17'd36525;
   localparam logic [14:0] C_RECIP  = 15'd29397;
   localparam logic [19:0] E_DIV    = 20'd306001;
   localparam logic [18:0] E_RECIP  = 19'd270000;
   localparam logic [10:0] MS_DIV   = 11'd1000;
   localparam logic [17:0] MS_RECIP = 18'd134217;
   localparam logic [6:0]  SIXTY    = 7'd60;
   localparam logic [11:0] S_RECIP  = 12'd2184;
   localparam logic [5:0]  M_RECIP  = 6'd34;

   // floor(30.6001 * e) for the month index e
   function automatic logic [8:0] e_offset(input logic [3:0] e);
      logic [8:0] r;
      unique case (e)
         4'd0:  r = 9'd0;
         4'd1:  r = 9'd30;
         4'd2:  r = 9'd61;
         4'd3:  r = 9'd91;
         4'd4:  r = 9'd122;
         4'd5:  r = 9'd153;
         4'd6:  r = 9'd183;
         4'd7:  r = 9'd214;
         4'd8:  r = 9'd244;
         4'd9:  r = 9'd275;
         4'd10: r = 9'd306;
         4'd11: r = 9'd336;
         4'd12: r = 9'd367;
         4'd13: r = 9'd397;
         4'd14: r = 9'd428;
         4'd15: r = 9'd459;
      endcase
      return r;
   endfunction

endpackage

>>> src/julian_day_to_calendar_top.sv
// pipeline: 14 register stages; a response is valid once its request reaches the last stage
// throughput: one per cycle unless rsp_stall; a full stage holds only while the next one holds
// bubbles are squeezed out, so new requests enter while a finished response is stalled
// reset: synchronous, active high; clears every stage valid bit, data registers keep garbage
`timescale 1ns / 1ps

module julian_day_to_calendar_top
   import jdc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DAY_W-1:0]  req_day_index,
   input  logic [MS_W-1:0]          req_ms_of_day,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [YEAR_W-1:0] rsp_year,
   output logic [MON_W-1:0]         rsp_month,
   output logic [DOM_W-1:0]         rsp_day_of_month,
   output logic [HR_W-1:0]          rsp_hour,
   output logic [MIN_W-1:0]         rsp_minute,
   output logic [SEC_W-1:0]         rsp_second,
   output logic [MSEC_W-1:0]        rsp_millisecond
);

   // stage valid bits and per-stage advance
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   logic [NUM_STAGES:1] ready;

   always_comb begin
      ready[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      valid_in[1] = req_valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !ready[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   // stage 1: julian day number, gregorian test, millisecond saturation
   logic signed [23:0] s1_z_in, s1_z_ff;
   logic               s1_greg_in, s1_greg_ff;
   logic signed [25:0] al_num_wide;
   logic [24:0]        s1_num_al_in, s1_num_al_ff;
   logic [MS_W-1:0]    s1_ms_in, s1_ms_ff;

   assign s1_z_in      = 24'(req_day_index) + JD_J2000;
   assign s1_greg_in   = req_day_index >= GREG_DAY_INDEX;
   assign al_num_wide  = 26'(req_day_index) * 26'sd4 + AL_NUM_OFFSET;
   assign s1_num_al_in = s1_greg_in ? al_num_wide[24:0] : '0;
   assign s1_ms_in     = (req_ms_of_day > MS_MAX) ? MS_MAX : req_ms_of_day;

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         s1_z_ff      <= s1_z_in;
         s1_greg_ff   <= s1_greg_in;
         s1_num_al_ff <= s1_num_al_in;
         s1_ms_ff     <= s1_ms_in;
      end
   end

   // stage 2: reciprocal products for alpha and seconds
   logic signed [23:0] s2_z_ff;
   logic               s2_greg_ff;
   logic [24:0]        s2_num_al_ff;
   logic [32:0]        s2_prod_al_in, s2_prod_al_ff;
   logic [MS_W-1:0]    s2_ms_ff;
   logic [44:0]        s2_prod_s_in, s2_prod_s_ff;

   assign s2_prod_al_in = 33'(s1_num_al_ff) * 33'(AL_RECIP);
   assign s2_prod_s_in  = 45'(s1_ms_ff) * 45'(MS_RECIP);

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         s2_z_ff       <= s1_z_ff;
         s2_greg_ff    <= s1_greg_ff;
         s2_num_al_ff  <= s1_num_al_ff;
         s2_prod_al_ff <= s2_prod_al_in;
         s2_ms_ff      <= s1_ms_ff;
         s2_prod_s_ff  <= s2_prod_s_in;
      end
   end

   // stage 3: quotient estimates and remainders
   logic signed [23:0] s3_z_ff;
   logic               s3_greg_ff;
   logic [7:0]         s3_q_al_in, s3_q_al_ff;
   logic [24:0]        rem_al_wide;
   logic [18:0]        s3_rem_al_in, s3_rem_al_ff;
   logic [16:0]        s3_q_s_in, s3_q_s_ff;
   logic [MS_W-1:0]    rem_s_wide;
   logic [10:0]        s3_rem_s_in, s3_rem_s_ff;

   assign s3_q_al_in   = s2_prod_al_ff[32:25];
   assign rem_al_wide  = s2_num_al_ff - 25'(s3_q_al_in) * 25'(AL_DIV);
   assign s3_rem_al_in = rem_al_wide[18:0];
   assign s3_q_s_in    = s2_prod_s_ff[43:27];
   assign rem_s_wide   = s2_ms_ff - 27'(s3_q_s_in) * 27'(MS_DIV);
   assign s3_rem_s_in  = rem_s_wide[10:0];

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         s3_z_ff      <= s2_z_ff;
         s3_greg_ff   <= s2_greg_ff;
         s3_q_al_ff   <= s3_q_al_in;
         s3_rem_al_ff <= s3_rem_al_in;
         s3_q_s_ff    <= s3_q_s_in;
         s3_rem_s_ff  <= s3_rem_s_in;
      end
   end

   // stage 4: quotient correction for alpha and seconds
   logic signed [23:0] s4_z_ff;
   logic               s4_greg_ff;
   logic               al_fix, s_fix;
   logic [7:0]         s4_al_in, s4_al_ff;
   logic [16:0]        s4_s_tot_in, s4_s_tot_ff;
   logic [MSEC_W-1:0]  s4_msec_in, s4_msec_ff;
   logic [10:0]        msec_wide;

   assign al_fix      = s3_rem_al_ff >= AL_DIV;
   assign s4_al_in    = s3_q_al_ff + 8'(al_fix);
   assign s_fix       = s3_rem_s_ff >= MS_DIV;
   assign s4_s_tot_in = s3_q_s_ff + 17'(s_fix);
   assign msec_wide   = s_fix ? s3_rem_s_ff - MS_DIV : s3_rem_s_ff;
   assign s4_msec_in  = msec_wide[MSEC_W-1:0];

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         s4_z_ff     <= s3_z_ff;
         s4_greg_ff  <= s3_greg_ff;
         s4_al_ff    <= s4_al_in;
         s4_s_tot_ff <= s4_s_tot_in;
         s4_msec_ff  <= s4_msec_in;
      end
   end

   // stage 5: b = a + 1524, minutes reciprocal product
   logic [7:0]         adj;
   logic signed [23:0] s5_b_in, s5_b_ff;
   logic [16:0]        s5_s_tot_ff;
   logic [28:0]        s5_prod_m_in, s5_prod_m_ff;
   logic [MSEC_W-1:0]  s5_msec_ff;

   assign adj          = s4_greg_ff ? 8'd1 + s4_al_ff - (s4_al_ff >> 2) : 8'd0;
   assign s5_b_in      = s4_z_ff + B_OFFSET + $signed({16'd0, adj});
   assign s5_prod_m_in = 29'(s4_s_tot_ff) * 29'(S_RECIP);

   always_ff @(posedge clock) begin
      if (ready[5]) begin
         s5_b_ff      <= s5_b_in;
         s5_s_tot_ff  <= s4_s_tot_ff;
         s5_prod_m_ff <= s5_prod_m_in;
         s5_msec_ff   <= s4_msec_ff;
      end
   end

   // stage 6: biased numerator for c, minute estimate
   logic signed [23:0] s6_b_ff;
   logic signed [31:0] np_wide;
   logic [29:0]        s6_np_in, s6_np_ff;
   logic [10:0]        s6_q_m_in, s6_q_m_ff;
   logic [16:0]        rem_m_wide;
   logic [6:0]         s6_rem_m_in, s6_rem_m_ff;
   logic [MSEC_W-1:0]  s6_msec_ff;

   assign np_wide     = 32'(s5_b_ff) * 32'sd100 + C_NUM_OFFSET;
   assign s6_np_in    = np_wide[29:0];
   assign s6_q_m_in   = s5_prod_m_ff[27:17];
   assign rem_m_wide  = s5_s_tot_ff - 17'(s6_q_m_in) * 17'(SIXTY);
   assign s6_rem_m_in = rem_m_wide[6:0];

   always_ff @(posedge clock) begin
      if (ready[6]) begin
         s6_b_ff     <= s5_b_ff;
         s6_np_ff    <= s6_np_in;
         s6_q_m_ff   <= s6_q_m_in;
         s6_rem_m_ff <= s6_rem_m_in;
         s6_msec_ff  <= s5_msec_ff;
      end
   end

   // stage 7: c reciprocal product, minute and second correction
   logic signed [23:0] s7_b_ff;
   logic [29:0]        s7_np_ff;
   logic [44:0]        s7_prod_c_in, s7_prod_c_ff;
   logic               m_fix;
   logic [10:0]        s7_m_tot_in, s7_m_tot_ff;
   logic [6:0]         sec_wide;
   logic [SEC_W-1:0]   s7_sec_in, s7_sec_ff;
   logic [MSEC_W-1:0]  s7_msec_ff;

   assign s7_prod_c_in = 45'(s6_np_ff) * 45'(C_RECIP);
   assign m_fix        = s6_rem_m_ff >= SIXTY;
   assign s7_m_tot_in  = s6_q_m_ff + 11'(m_fix);
   assign sec_wide     = m_fix ? s6_rem_m_ff - SIXTY : s6_rem_m_ff;
   assign s7_sec_in    = sec_wide[SEC_W-1:0];

   always_ff @(posedge clock) begin
      if (ready[7]) begin
         s7_b_ff      <= s6_b_ff;
         s7_np_ff     <= s6_np_ff;
         s7_prod_c_ff <= s7_prod_c_in;
         s7_m_tot_ff  <= s7_m_tot_in;
         s7_sec_ff    <= s7_sec_in;
         s7_msec_ff   <= s6_msec_ff;
      end
   end

   // stage 8: c estimate and remainder, hour reciprocal product
   logic signed [23:0] s8_b_ff;
   logic [14:0]        s8_q_c_in, s8_q_c_ff;
   logic [29:0]        rem_c_wide;
   logic [16:0]        s8_rem_c_in, s8_rem_c_ff;
   logic [10:0]        s8_m_tot_ff;
   logic [16:0]        s8_prod_h_in, s8_prod_h_ff;
   logic [SEC_W-1:0]   s8_sec_ff;
   logic [MSEC_W-1:0]  s8_msec_ff;

   assign s8_q_c_in    = s7_prod_c_ff[44:30];
   assign rem_c_wide   = s7_np_ff - 30'(s8_q_c_in) * 30'(C_DIV);
   assign s8_rem_c_in  = rem_c_wide[16:0];
   assign s8_prod_h_in = 17'(s7_m_tot_ff) * 17'(M_RECIP);

   always_ff @(posedge clock) begin
      if (ready[8]) begin
         s8_b_ff      <= s7_b_ff;
         s8_q_c_ff    <= s8_q_c_in;
         s8_rem_c_ff  <= s8_rem_c_in;
         s8_m_tot_ff  <= s7_m_tot_ff;
         s8_prod_h_ff <= s8_prod_h_in;
         s8_sec_ff    <= s7_sec_ff;
         s8_msec_ff   <= s7_msec_ff;
      end
   end

   // stage 9: c correction and bias removal, hour estimate
   logic signed [23:0] s9_b_ff;
   logic               c_fix;
   logic [15:0]        qc_fixed;
   logic signed [15:0] s9_c_in, s9_c_ff;
   logic [4:0]         s9_q_h_in, s9_q_h_ff;
   logic [10:0]        rem_h_wide;
   logic [6:0]         s9_rem_h_in, s9_rem_h_ff;
   logic [SEC_W-1:0]   s9_sec_ff;
   logic [MSEC_W-1:0]  s9_msec_ff;

   assign c_fix       = s8_rem_c_ff >= C_DIV;
   assign qc_fixed    = 16'(s8_q_c_ff) + 16'(c_fix);
   assign s9_c_in     = $signed(qc_fixed) - C_BIAS;
   assign s9_q_h_in   = s8_prod_h_ff[15:11];
   assign rem_h_wide  = s8_m_tot_ff - 11'(s9_q_h_in) * 11'(SIXTY);
   assign s9_rem_h_in = rem_h_wide[6:0];

   always_ff @(posedge clock) begin
      if (ready[9]) begin
         s9_b_ff     <= s8_b_ff;
         s9_c_ff     <= s9_c_in;
         s9_q_h_ff   <= s9_q_h_in;
         s9_rem_h_ff <= s9_rem_h_in;
         s9_sec_ff   <= s8_sec_ff;
         s9_msec_ff  <= s8_msec_ff;
      end
   end

   // stage 10: day of year offset b - floor(365.25 c), hour and minute correction
   logic signed [31:0] prod_d;
   logic signed [31:0] bd_wide;
   logic [8:0]         s10_bd_in, s10_bd_ff;
   logic signed [15:0] s10_c_ff;
   logic               h_fix;
   logic [HR_W-1:0]    s10_hr_in, s10_hr_ff;
   logic [6:0]         min_wide;
   logic [MIN_W-1:0]   s10_min_in, s10_min_ff;
   logic [SEC_W-1:0]   s10_sec_ff;
   logic [MSEC_W-1:0]  s10_msec_ff;

   assign prod_d     = 32'(s9_c_ff) * 32'sd1461;
   assign bd_wide    = 32'(s9_b_ff) - (prod_d >>> 2);
   assign s10_bd_in  = bd_wide[8:0];
   assign h_fix      = s9_rem_h_ff >= SIXTY;
   assign s10_hr_in  = s9_q_h_ff + 5'(h_fix);
   assign min_wide   = h_fix ? s9_rem_h_ff - SIXTY : s9_rem_h_ff;
   assign s10_min_in = min_wide[MIN_W-1:0];

   always_ff @(posedge clock) begin
      if (ready[10]) begin
         s10_bd_ff   <= s10_bd_in;
         s10_c_ff    <= s9_c_ff;
         s10_hr_ff   <= s10_hr_in;
         s10_min_ff  <= s10_min_in;
         s10_sec_ff  <= s9_sec_ff;
         s10_msec_ff <= s9_msec_ff;
      end
   end

   // stage 11: month index reciprocal product
   logic [27:0]        s11_prod_e_in, s11_prod_e_ff;
   logic [8:0]         s11_bd_ff;
   logic signed [15:0] s11_c_ff;
   logic [HR_W-1:0]    s11_hr_ff;
   logic [MIN_W-1:0]   s11_min_ff;
   logic [SEC_W-1:0]   s11_sec_ff;
   logic [MSEC_W-1:0]  s11_msec_ff;

   assign s11_prod_e_in = 28'(s10_bd_ff) * 28'(E_RECIP);

   always_ff @(posedge clock) begin
      if (ready[11]) begin
         s11_prod_e_ff <= s11_prod_e_in;
         s11_bd_ff     <= s10_bd_ff;
         s11_c_ff      <= s10_c_ff;
         s11_hr_ff     <= s10_hr_ff;
         s11_min_ff    <= s10_min_ff;
         s11_sec_ff    <= s10_sec_ff;
         s11_msec_ff   <= s10_msec_ff;
      end
   end

   // stage 12: month index estimate and remainder
   logic [3:0]         s12_q_e_in, s12_q_e_ff;
   logic [22:0]        rem_e_wide;
   logic [19:0]        s12_rem_e_in, s12_rem_e_ff;
   logic [8:0]         s12_bd_ff;
   logic signed [15:0] s12_c_ff;
   logic [HR_W-1:0]    s12_hr_ff;
   logic [MIN_W-1:0]   s12_min_ff;
   logic [SEC_W-1:0]   s12_sec_ff;
   logic [MSEC_W-1:0]  s12_msec_ff;

   assign s12_q_e_in   = s11_prod_e_ff[26:23];
   assign rem_e_wide   = 23'(s11_bd_ff) * 23'd10000 - 23'(s12_q_e_in) * 23'(E_DIV);
   assign s12_rem_e_in = rem_e_wide[19:0];

   always_ff @(posedge clock) begin
      if (ready[12]) begin
         s12_q_e_ff   <= s12_q_e_in;
         s12_rem_e_ff <= s12_rem_e_in;
         s12_bd_ff    <= s11_bd_ff;
         s12_c_ff     <= s11_c_ff;
         s12_hr_ff    <= s11_hr_ff;
         s12_min_ff   <= s11_min_ff;
         s12_sec_ff   <= s11_sec_ff;
         s12_msec_ff  <= s11_msec_ff;
      end
   end

   // stage 13: month index correction
   logic [3:0]         s13_e_in, s13_e_ff;
   logic [8:0]         s13_bd_ff;
   logic signed [15:0] s13_c_ff;
   logic [HR_W-1:0]    s13_hr_ff;
   logic [MIN_W-1:0]   s13_min_ff;
   logic [SEC_W-1:0]   s13_sec_ff;
   logic [MSEC_W-1:0]  s13_msec_ff;

   assign s13_e_in = s12_q_e_ff + 4'(s12_rem_e_ff >= E_DIV);

   always_ff @(posedge clock) begin
      if (ready[13]) begin
         s13_e_ff    <= s13_e_in;
         s13_bd_ff   <= s12_bd_ff;
         s13_c_ff    <= s12_c_ff;
         s13_hr_ff   <= s12_hr_ff;
         s13_min_ff  <= s12_min_ff;
         s13_sec_ff  <= s12_sec_ff;
         s13_msec_ff <= s12_msec_ff;
      end
   end

   // stage 14: day of month, month and year into the output register
   logic                     early_month;
   logic [8:0]               dom_wide;
   logic signed [15:0]       year_wide;
   logic [DOM_W-1:0]         s14_dom_in, s14_dom_ff;
   logic [MON_W-1:0]         s14_mon_in, s14_mon_ff;
   logic signed [YEAR_W-1:0] s14_year_in, s14_year_ff;
   logic [HR_W-1:0]          s14_hr_ff;
   logic [MIN_W-1:0]         s14_min_ff;
   logic [SEC_W-1:0]         s14_sec_ff;
   logic [MSEC_W-1:0]        s14_msec_ff;

   assign early_month = s13_e_ff < 4'd14;
   assign dom_wide    = s13_bd_ff - e_offset(s13_e_ff);
   assign s14_dom_in  = dom_wide[DOM_W-1:0];
   assign s14_mon_in  = early_month ? s13_e_ff - 4'd1 : s13_e_ff - 4'd13;
   assign year_wide   = early_month ? s13_c_ff - YEAR_OFS_LATE : s13_c_ff - YEAR_OFS_EARLY;
   assign s14_year_in = year_wide[YEAR_W-1:0];

   always_ff @(posedge clock) begin
      if (ready[14]) begin
         s14_dom_ff  <= s14_dom_in;
         s14_mon_ff  <= s14_mon_in;
         s14_year_ff <= s14_year_in;
         s14_hr_ff   <= s13_hr_ff;
         s14_min_ff  <= s13_min_ff;
         s14_sec_ff  <= s13_sec_ff;
         s14_msec_ff <= s13_msec_ff;
      end
   end

   assign rsp_year         = s14_year_ff;
   assign rsp_month        = s14_mon_ff;
   assign rsp_day_of_month = s14_dom_ff;
   assign rsp_hour         = s14_hr_ff;
   assign rsp_minute       = s14_min_ff;
   assign rsp_second       = s14_sec_ff;
   assign rsp_millisecond  = s14_msec_ff;

endmodule

>>> src/jdc_checker.sv
`timescale 1ns / 1ps

module jdc_checker
   import jdc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [YEAR_W-1:0] rsp_year,
   input logic [MON_W-1:0]         rsp_month,
   input logic [DOM_W-1:0]         rsp_day_of_month,
   input logic [HR_W-1:0]          rsp_hour,
   input logic [MIN_W-1:0]         rsp_minute,
   input logic [SEC_W-1:0]         rsp_second,
   input logic [MSEC_W-1:0]        rsp_millisecond
);

   // date fields of a response stay inside the calendar
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= 4'd1 && rsp_month <= 4'd12
                 && rsp_day_of_month >= 5'd1)
      else $error("response date out of range");

   // time fields of a response stay inside the day
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hour <= 5'd23 && rsp_minute <= 6'd59
                 && rsp_second <= 6'd59 && rsp_millisecond <= 10'd999)
      else $error("response time out of range");

   // an empty output register never blocks the request side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no pending response");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_year) && $stable(rsp_month)
         && $stable(rsp_day_of_month) && $stable(rsp_hour) && $stable(rsp_minute)
         && $stable(rsp_second) && $stable(rsp_millisecond))
      else $error("stalled response changed");

endmodule

bind julian_day_to_calendar_top jdc_checker u_jdc_checker (.*);
